// ===== sv/mlt_pkg.sv =====
package mlt_pkg;

  localparam int unsigned MAX_IDENT_LEN_DEF = 63;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned KIND_W      = 4;
  localparam int unsigned VALUE_W     = 31;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned OUT_FIELD_W = VALUE_W + CHAR_W + POS_W + POS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    K_IDENT   = 4'd0,
    K_NUMBER  = 4'd1,
    K_PRINT   = 4'd2,
    K_PLUS    = 4'd3,
    K_MINUS   = 4'd4,
    K_STAR    = 4'd5,
    K_SLASH   = 4'd6,
    K_PERCENT = 4'd7,
    K_EQUAL   = 4'd8,
    K_LPAREN  = 4'd9,
    K_RPAREN  = 4'd10,
    K_NEWLINE = 4'd11,
    K_END     = 4'd12,
    K_ERROR   = 4'd13
  } tok_kind_e;

  // which source feeds the output register
  typedef enum logic [2:0] {
    SEL_NUMBER,
    SEL_PRINT,
    SEL_IDENT,
    SEL_FRESH,
    SEL_ERROR
  } emit_sel_e;

  typedef struct packed {
    logic      accept;
    logic      acc_load;
    logic      acc_step;
    logic      id_start;
    logic      id_append;
    logic      rd_first;
    logic      rd_next;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic is_space;
    logic is_digit;
    logic is_alpha;
    logic is_token;
    logic is_zero;
    logic count_full;
    logic is_print;
    logic flush_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/mini_language_tokenizer.sv =====
// channel  dir  fields
// s_axis   in   tdata[7:0] char_byte
// m_axis   out  tdata number_value, text_byte, char_index, ident_length;
//               tuser token_kind; tlast last_of_item
//
// a byte is accepted in the wait state, then lexed in the lex state
// a byte that closes a number or print is lexed again after its item; one
// that closes an identifier first flushes the ram, an item per character
// the output register holds a stalled item; lexing waits until it drains
// reset returns to the idle lexer; the identifier buffer needs no clearing
module mini_language_tokenizer import mlt_pkg::*; #(
  parameter int unsigned MAX_IDENT_LEN = MAX_IDENT_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [CHAR_W-1:0]      s_axis_tdata_i,   // [7:0] char_byte
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [30:0] number_value, [38:31] text_byte, [44:39] char_index,
  // [50:45] ident_length, [55:51] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [KIND_W-1:0]      m_axis_tuser_o,   // [3:0] token_kind
  output logic                   m_axis_tlast_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mlt_dp #(
    .MAX_IDENT_LEN (MAX_IDENT_LEN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== sv/mlt_ram.sv =====
module mlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 63,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mlt_dp.sv =====
module mlt_dp import mlt_pkg::*; #(
  parameter int unsigned MAX_IDENT_LEN = MAX_IDENT_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [CHAR_W-1:0]      s_tdata_i,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  output logic [KIND_W-1:0]      m_tuser_o,
  output logic                   m_tlast_o
);

  localparam int unsigned AW = (MAX_IDENT_LEN > 1) ? $clog2(MAX_IDENT_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_IDENT_LEN + 1);
  localparam int unsigned KW_LEN = 5;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
  localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_UA      = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ      = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA      = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ      = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

  localparam logic [VALUE_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

  function automatic logic [CHAR_W-1:0] kw_print(input logic [2:0] pos);
    logic [CHAR_W-1:0] ch;
    case (pos)
      3'd0:    ch = 8'h70;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h69;
      3'd3:    ch = 8'h6E;
      3'd4:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  logic [CHAR_W-1:0]      char_q, char_d;
  logic [VALUE_W-1:0]     acc_q, acc_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   pm_q, pm_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  logic [KIND_W-1:0]      out_kind_q, out_kind_d;
  logic [VALUE_W-1:0]     out_value_q, out_value_d;
  logic [CHAR_W-1:0]      out_text_q, out_text_d;
  logic [POS_W-1:0]       out_idx_q, out_idx_d;
  logic [POS_W-1:0]       out_len_q, out_len_d;
  logic                   out_last_q, out_last_d;

  logic [VALUE_W+3:0]     prod;
  logic                   is_digit, is_alpha, is_space, is_token;
  tok_kind_e              fresh_kind;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [CHAR_W-1:0]      ram_rdata;
  logic                   out_free;

  assign is_digit = (char_q >= CH_0) && (char_q <= CH_9);
  assign is_alpha = ((char_q >= CH_LA) && (char_q <= CH_LZ)) ||
                    ((char_q >= CH_UA) && (char_q <= CH_UZ));
  assign is_space = (char_q == CH_SPACE) || (char_q == CH_TAB) || (char_q == CH_CR);

  always_comb begin
    is_token   = 1'b1;
    fresh_kind = K_END;
    case (char_q)
      CH_PLUS:    fresh_kind = K_PLUS;
      CH_MINUS:   fresh_kind = K_MINUS;
      CH_STAR:    fresh_kind = K_STAR;
      CH_SLASH:   fresh_kind = K_SLASH;
      CH_PERCENT: fresh_kind = K_PERCENT;
      CH_EQUAL:   fresh_kind = K_EQUAL;
      CH_LPAREN:  fresh_kind = K_LPAREN;
      CH_RPAREN:  fresh_kind = K_RPAREN;
      CH_NL:      fresh_kind = K_NEWLINE;
      CH_NUL:     fresh_kind = K_END;
      default:    is_token   = 1'b0;
    endcase
  end

  assign out_free = !out_valid_q || m_tready_i;

  assign stat_o.is_space   = is_space;
  assign stat_o.is_digit   = is_digit;
  assign stat_o.is_alpha   = is_alpha;
  assign stat_o.is_token   = is_token;
  assign stat_o.is_zero    = (char_q == CH_NUL);
  assign stat_o.count_full = (count_q >= CW'(MAX_IDENT_LEN));
  assign stat_o.is_print   = pm_q && (count_q == CW'(KW_LEN));
  assign stat_o.flush_last = ((CW'(idx_q) + CW'(1)) == count_q);
  assign stat_o.out_free   = out_free;

  // acc * 10 + digit as two shifted copies
  assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (VALUE_W+4)'(char_q[3:0]);

  always_comb begin
    char_d  = char_q;
    acc_d   = acc_q;
    count_d = count_q;
    pm_d    = pm_q;
    idx_d   = idx_q;
    if (cmd_i.accept) begin
      char_d = s_tdata_i;
    end
    if (cmd_i.acc_load) begin
      acc_d = VALUE_W'(char_q[3:0]);
    end else if (cmd_i.acc_step) begin
      acc_d = (prod > {4'b0, NUM_MAX}) ? NUM_MAX : prod[VALUE_W-1:0];
    end
    if (cmd_i.id_start) begin
      count_d = CW'(1);
      pm_d    = (char_q == kw_print(3'd0));
    end else if (cmd_i.id_append) begin
      count_d = count_q + CW'(1);
      if (count_q < CW'(KW_LEN)) begin
        pm_d = pm_q && (char_q == kw_print(count_q[2:0]));
      end
    end
    if (cmd_i.rd_first) begin
      idx_d = '0;
    end else if (cmd_i.rd_next) begin
      idx_d = idx_q + AW'(1);
    end
  end

  assign ram_we    = cmd_i.id_start || cmd_i.id_append;
  assign ram_waddr = cmd_i.id_start ? '0 : count_q[AW-1:0];
  assign ram_re    = cmd_i.rd_first || cmd_i.rd_next;
  assign ram_raddr = cmd_i.rd_first ? '0 : idx_q + AW'(1);

  mlt_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_IDENT_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (char_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;
    out_text_d  = out_text_q;
    out_idx_d   = out_idx_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_value_d = '0;
      out_text_d  = '0;
      out_idx_d   = '0;
      out_len_d   = '0;
      out_last_d  = cmd_i.emit_last;
      case (cmd_i.emit_sel)
        SEL_NUMBER: begin
          out_kind_d  = K_NUMBER;
          out_value_d = acc_q;
        end
        SEL_PRINT: begin
          out_kind_d = K_PRINT;
        end
        SEL_IDENT: begin
          out_kind_d = K_IDENT;
          out_text_d = ram_rdata;
          out_idx_d  = POS_W'(idx_q);
          out_len_d  = POS_W'(count_q);
        end
        SEL_FRESH: begin
          out_kind_d = fresh_kind;
        end
        SEL_ERROR: begin
          out_kind_d = K_ERROR;
          out_text_d = char_q;
        end
        default: begin
          out_kind_d = K_ERROR;
        end
      endcase
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q      <= char_d;
    acc_q       <= acc_d;
    pm_q        <= pm_d;
    idx_q       <= idx_d;
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
    out_text_q  <= out_text_d;
    out_idx_q   <= out_idx_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_len_q, out_idx_q,
                       out_text_q, out_value_q};

endmodule

// ===== sv/mlt_ctrl.sv =====
module mlt_ctrl import mlt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_LEX,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    M_IDLE,
    M_NUM,
    M_IDENT,
    M_DISCARD
  } mode_e;

  state_e  state_q, state_d;
  mode_e   mode_q, mode_d;
  dp_cmd_t cmd;
  logic    fresh_quiet;

  // a fresh lex of these bytes gives no result of its own
  assign fresh_quiet = stat_i.is_space || stat_i.is_digit || stat_i.is_alpha;

  always_comb begin
    cmd          = '0;
    cmd.emit_sel = SEL_FRESH;
    state_d      = state_q;
    mode_d       = mode_q;
    case (state_q)
      ST_WAIT: begin
        if (s_tvalid_i) begin
          cmd.accept = 1'b1;
          state_d    = ST_LEX;
        end
      end
      ST_LEX: begin
        if (stat_i.out_free) begin
          case (mode_q)
            M_DISCARD: begin
              if (stat_i.is_zero) begin
                mode_d = M_IDLE;
              end
              state_d = ST_WAIT;
            end
            M_NUM: begin
              if (stat_i.is_digit) begin
                cmd.acc_step = 1'b1;
                state_d      = ST_WAIT;
              end else begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = SEL_NUMBER;
                cmd.emit_last = fresh_quiet;
                mode_d        = M_IDLE;
              end
            end
            M_IDENT: begin
              if (stat_i.is_digit || stat_i.is_alpha) begin
                if (stat_i.count_full) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = SEL_ERROR;
                  cmd.emit_last = 1'b1;
                  mode_d        = M_DISCARD;
                end else begin
                  cmd.id_append = 1'b1;
                end
                state_d = ST_WAIT;
              end else if (stat_i.is_print) begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = SEL_PRINT;
                cmd.emit_last = fresh_quiet;
                mode_d        = M_IDLE;
              end else begin
                cmd.rd_first = 1'b1;
                state_d      = ST_FLUSH;
              end
            end
            M_IDLE: begin
              state_d = ST_WAIT;
              if (stat_i.is_space) begin
                mode_d = M_IDLE;
              end else if (stat_i.is_digit) begin
                cmd.acc_load = 1'b1;
                mode_d       = M_NUM;
              end else if (stat_i.is_alpha) begin
                cmd.id_start = 1'b1;
                mode_d       = M_IDENT;
              end else if (stat_i.is_token) begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = SEL_FRESH;
                cmd.emit_last = 1'b1;
              end else begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = SEL_ERROR;
                cmd.emit_last = 1'b1;
                mode_d        = M_DISCARD;
              end
            end
            default: begin
              mode_d  = M_IDLE;
              state_d = ST_WAIT;
            end
          endcase
        end
      end
      ST_FLUSH: begin
        // read data for the current index is in the ram output register
        if (stat_i.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_IDENT;
          cmd.emit_last = stat_i.flush_last && fresh_quiet;
          if (stat_i.flush_last) begin
            mode_d  = M_IDLE;
            state_d = ST_LEX;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
      mode_q  <= M_IDLE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  assign s_tready_o = (state_q == ST_WAIT);
  assign cmd_o      = cmd;

endmodule

// ===== sv/mlt_checker.sv =====
module mlt_checker import mlt_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_tvalid_i,
  input logic                   m_tready_i,
  input logic [OUT_TDATA_W-1:0] m_tdata_i,
  input logic [KIND_W-1:0]      m_tuser_i,
  input logic                   m_tlast_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) &&
      $stable(m_tuser_i) && $stable(m_tlast_i))
    else $error("output item changed while stalled");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i != K_IDENT) |-> (m_tdata_i[50:39] == '0))
    else $error("index or length set on a non-identifier item");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i != K_NUMBER) |-> (m_tdata_i[30:0] == '0))
    else $error("value set on a non-number item");

  // operators, newline, end and error always close their byte
  a_fresh_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i >= K_PLUS) |-> m_tlast_i)
    else $error("single-result token without tlast");

endmodule

bind mini_language_tokenizer mlt_checker u_mlt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);

// ===== tb/mini_language_tokenizer_test.sv =====
module mini_language_tokenizer_test;
  import mlt_pkg::*;

  localparam int          CLK_PERIOD = 12;
  localparam int unsigned IDENT_MAX  = MAX_IDENT_LEN_DEF;
  localparam logic [7:0]  CH_END     = 8'h00;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_NL      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [30:0] NUM_SAT    = '1;

  typedef enum logic [1:0] {LX_IDLE, LX_NUMBER, LX_IDENT, LX_SKIP} lex_state_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [30:0] value;
    logic [7:0]  text;
    logic [5:0]  idx;
    logic [5:0]  len;
    logic        last;
  } token_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [CHAR_W-1:0]      s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [KIND_W-1:0]      m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  mini_language_tokenizer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // lexer state mirrored by the predictor
  lex_state_e  lx_state;
  logic [30:0] num_acc;
  logic [7:0]  id_buf [IDENT_MAX];
  int unsigned id_cnt;
  token_t      tok_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned bytes_sent;
  int unsigned toks_checked;
  int unsigned ident_chars;
  int unsigned error_toks;
  int unsigned err_count;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic bit is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic token_t make_tok(input tok_kind_e kind, input logic [30:0] value,
                                      input logic [7:0] text, input logic [5:0] idx,
                                      input logic [5:0] len);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.text  = text;
    t.idx   = idx;
    t.len   = len;
    t.last  = 1'b0;
    return t;
  endfunction

  // works out the tokens that one accepted byte releases
  function automatic void predict_byte(input logic [7:0] c);
    token_t      out_q[$];
    token_t      tail;
    logic [34:0] prod;
    bit          settled;
    settled = 1'b0;
    case (lx_state)
      LX_SKIP: begin
        if (c == CH_END) lx_state = LX_IDLE;
        settled = 1'b1;
      end
      LX_NUMBER: begin
        if (is_dec(c)) begin
          prod = num_acc * 35'd10 + (c - "0");
          num_acc = (prod > NUM_SAT) ? NUM_SAT : prod[30:0];
          settled = 1'b1;
        end else begin
          out_q.push_back(make_tok(K_NUMBER, num_acc, '0, '0, '0));
          num_acc = '0;
          lx_state = LX_IDLE;
        end
      end
      LX_IDENT: begin
        if (is_dec(c) || is_letter(c)) begin
          if (id_cnt >= IDENT_MAX) begin
            id_cnt = 0;
            lx_state = LX_SKIP;
            out_q.push_back(make_tok(K_ERROR, '0, c, '0, '0));
          end else begin
            id_buf[id_cnt] = c;
            id_cnt++;
          end
          settled = 1'b1;
        end else begin
          if (id_cnt == 5 && {id_buf[0], id_buf[1], id_buf[2], id_buf[3], id_buf[4]} == "print")
            out_q.push_back(make_tok(K_PRINT, '0, '0, '0, '0));
          else
            for (int i = 0; i < id_cnt; i++)
              out_q.push_back(make_tok(K_IDENT, '0, id_buf[i], 6'(i), 6'(id_cnt)));
          id_cnt = 0;
          lx_state = LX_IDLE;
        end
      end
      default: ;
    endcase
    // the byte that closed a token is lexed again from the start state
    if (!settled) begin
      if (is_dec(c)) begin
        lx_state = LX_NUMBER;
        num_acc = c - "0";
      end else if (is_letter(c)) begin
        lx_state = LX_IDENT;
        id_buf[0] = c;
        id_cnt = 1;
      end else if (!(c == " " || c == CH_TAB || c == CH_CR)) begin
        lx_state = LX_IDLE;
        case (c)
          "+":     out_q.push_back(make_tok(K_PLUS, '0, '0, '0, '0));
          "-":     out_q.push_back(make_tok(K_MINUS, '0, '0, '0, '0));
          "*":     out_q.push_back(make_tok(K_STAR, '0, '0, '0, '0));
          "/":     out_q.push_back(make_tok(K_SLASH, '0, '0, '0, '0));
          "%":     out_q.push_back(make_tok(K_PERCENT, '0, '0, '0, '0));
          "=":     out_q.push_back(make_tok(K_EQUAL, '0, '0, '0, '0));
          "(":     out_q.push_back(make_tok(K_LPAREN, '0, '0, '0, '0));
          ")":     out_q.push_back(make_tok(K_RPAREN, '0, '0, '0, '0));
          CH_NL:   out_q.push_back(make_tok(K_NEWLINE, '0, '0, '0, '0));
          CH_END:  out_q.push_back(make_tok(K_END, '0, '0, '0, '0));
          default: begin
            out_q.push_back(make_tok(K_ERROR, '0, c, '0, '0));
            lx_state = LX_SKIP;
          end
        endcase
      end
    end
    if (out_q.size() > 0) begin
      tail = out_q.pop_back();
      tail.last = 1'b1;
      out_q.push_back(tail);
    end
    foreach (out_q[i]) tok_q.push_back(out_q[i]);
  endfunction

  function automatic logic [7:0] rand_alnum(input bit letters_only);
    int unsigned r;
    r = letters_only ? $urandom_range(0, 51) : $urandom_range(0, 61);
    if (r < 26) return 8'("a" + r);
    else if (r < 52) return 8'("A" + r - 26);
    else return 8'("0" + r - 52);
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 30) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // result side: compare each token, drive a random ready for the next edge
  always @(posedge clk_i) begin
    token_t got;
    token_t want;
    logic [OUT_TDATA_W-OUT_FIELD_W-1:0] pad;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind  = tok_kind_e'(m_axis_tuser_o);
      got.value = m_axis_tdata_o[30:0];
      got.text  = m_axis_tdata_o[38:31];
      got.idx   = m_axis_tdata_o[44:39];
      got.len   = m_axis_tdata_o[50:45];
      got.last  = m_axis_tlast_o;
      pad       = m_axis_tdata_o[OUT_TDATA_W-1:OUT_FIELD_W];
      toks_checked++;
      if (got.kind == K_IDENT) ident_chars++;
      if (got.kind == K_ERROR) error_toks++;
      if (tok_q.size() == 0) begin
        report_mismatch($sformatf("token kind %0d with nothing expected", got.kind));
      end else begin
        want = tok_q.pop_front();
        if (got !== want || pad !== '0)
          report_mismatch($sformatf(
            "kind %0d/%0d value %0d/%0d text %h/%h idx %0d/%0d len %0d/%0d last %b/%b pad %h",
            got.kind, want.kind, got.value, want.value, got.text, want.text,
            got.idx, want.idx, got.len, want.len, got.last, want.last, pad));
      end
    end
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // every operator, whitespace kind, keyword, end of text and unknown bytes
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_text("print\t(");
    send_text("Za9 ");
    send_text("+-*/%)\n");
    send_char("0");
    send_char(CH_CR);
    send_char("=");
    send_char(CH_END);
    // unknown byte, then a discarded one up to the end of text
    send_char(8'hFF);
    send_char(8'h80);
    send_char(CH_END);
  endtask

  // saturating number, identifier one char too long
  task automatic test_long_tokens();
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    send_text("99999999999+");
    send_char(rand_alnum(1'b1));
    repeat (IDENT_MAX) send_char(rand_alnum(1'b0));
    send_text("7+ q");
    send_char(CH_END);
  endtask

  task automatic send_random_text(input int unsigned budget);
    string       ops;
    string       odd;
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    ops = "+-*/%=()";
    odd = "!\"#$&',.:;<>?@[\\]^_`{|}~";
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
        repeat (len) send_char(8'("0" + $urandom_range(0, 9)));
      end else if (pick < 48) begin
        len = $urandom_range(1, 8);
        send_char(rand_alnum(1'b1));
        repeat (len - 1) send_char(rand_alnum(1'b0));
      end else if (pick < 53) begin
        send_text("print");
      end else if (pick < 78) begin
        send_char(ops[$urandom_range(0, 7)]);
      end else if (pick < 86) begin
        case ($urandom_range(0, 2))
          0:       send_char(" ");
          1:       send_char(CH_TAB);
          default: send_char(CH_CR);
        endcase
      end else if (pick < 91) begin
        send_char(CH_NL);
      end else if (pick < 94) begin
        send_char(CH_END);
      end else begin
        // broken text: an unknown byte, some noise, then the end of text
        if ($urandom_range(0, 1))
          send_char(8'($urandom_range(128, 255)));
        else
          send_char(odd[$urandom_range(0, odd.len() - 1)]);
        repeat ($urandom_range(0, 4)) send_char(8'($urandom));
        send_char(CH_END);
      end
    end
    send_char(CH_END);
  endtask

  task automatic test_random_text();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random_text(5);
    send_idle_pct = 73; recv_stall_pct = 0;  send_random_text(5);
    send_idle_pct = 0;  recv_stall_pct = 73; send_random_text(5);
    send_idle_pct = 37; recv_stall_pct = 37; send_random_text(5);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    m_axis_tready_i <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_sent     = 0;
    toks_checked   = 0;
    ident_chars    = 0;
    error_toks     = 0;
    err_count      = 0;
    lx_state       = LX_IDLE;
    num_acc        = '0;
    id_cnt         = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_tokens();
    test_random_text();
    s_axis_tvalid_i <= 1'b0;
    recv_stall_pct = 0;
    while (tok_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("fed %0d source bytes under four handshake mixes; checked %0d tokens",
             bytes_sent, toks_checked);
    $display("of those, %0d identifier characters and %0d error tokens",
             ident_chars, error_toks);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 300000);
    $display("timeout with %0d tokens still expected", tok_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
